@@ src/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants for the tread speed PI controller
// Field widths, register index codes, sequencer states and clamp limits.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

  localparam int NUM_W  = 16;  // signed dividend (error or integral)
  localparam int DVS_W  = 15;  // unsigned divisor register width
  localparam int QUO_W  = 17;  // signed quotient, holds +32768 magnitude
  localparam int LVL_W  = 8;   // drive level width
  localparam int CORR_W = 8;   // correction width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W  = QUO_W + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_DIV  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_DIV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_REF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LVL = 2'd3;

  // reset values
  localparam logic [DVS_W-1:0] PROP_DIV_RST  = 15'h007F;
  localparam logic [DVS_W-1:0] INTEG_DIV_RST = 15'h04FF;
  localparam logic [15:0]      INIT_REF_RST  = 16'd1000;
  localparam logic [LVL_W-1:0] START_LVL_RST = 8'd255;

  // clamp limits
  localparam logic signed [SUM_W-1:0]  CORR_MAX_WIDE = 18'sd127;
  localparam logic signed [SUM_W-1:0]  CORR_MIN_WIDE = -18'sd128;
  localparam logic signed [CORR_W-1:0] CORR_MAX = 8'sd127;
  localparam logic signed [CORR_W-1:0] CORR_MIN = -8'sd128;
  localparam logic [LVL_W-1:0]         LVL_MAX  = 8'd255;
  localparam logic [LVL_W-1:0]         LVL_MIN  = 8'd0;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIVP  = 4'b0010,
    S_DIVI  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ src/tsp_div.sv @@
// ----------------------------------------------------------------------------
// tsp_div: serial signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// A zero divisor divides by one.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_div
  import tsp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] numer,
  input  wire logic        [DVS_W-1:0] denom,
  output logic                         done,
  output logic signed [QUO_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic             neg;
  logic [DVS_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DVS_W-1:0] dvs;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= numer[NUM_W-1];
      quo   <= numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
      rem   <= '0;
      dvs   <= (denom == '0) ? DVS_W'(1) : denom;
      count <= CNT_W'(NUM_W - 1);
    end else if (busy) begin
      rem   <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo   <= {quo[NUM_W-2:0], ge};
      count <= count - CNT_W'(1);
    end
  end

  // sign applied on the way out; stable while done is high
  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

`default_nettype wire

@@ src/tread_speed_pi_sync.sv @@
// ----------------------------------------------------------------------------
// tread_speed_pi_sync: PI speed matching of the left tread to the right tread
// Captures encoder edge times, measures periods and trims the left drive level.
// ----------------------------------------------------------------------------
// Sequencing: a measured left edge starts the divider on the error in S_IDLE,
//   on the updated integral in S_DIVP; S_DIVI registers level and correction,
//   S_APPLY loads the output register. In_stall holds new words until S_IDLE, so
//   restart, first and right edges, handled in S_IDLE, pass without the divider;
//   a stalled word in the output register holds the next one.
// Reset: synchronous, active high; config and control registers reset, payload
//   ones do not; first-edge flags set, integral cleared, level 255, reference 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module tread_speed_pi_sync
  import tsp_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // item channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         mode,
  input  wire logic                         tread,
  input  wire logic [15:0]                  edge_time,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [LVL_W-1:0]                  drive_level,
  output logic signed [CORR_W-1:0]          correction,
  // configuration write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  // timestamps wrap at the timer width; periods never exceed 16 bits
  localparam int TW = (TIMER_BITS < 16) ? TIMER_BITS : 16;

  // configuration registers
  logic [DVS_W-1:0] prop_div;
  logic [DVS_W-1:0] integ_div;
  logic [15:0]      init_ref;
  logic [LVL_W-1:0] start_lvl;

  // controller state
  state_t           state;
  logic [1:0]       first_pending;
  logic [TW-1:0]    last_edge [2];
  logic [15:0]      reference_period;
  logic [15:0]      error_integral;
  logic [LVL_W-1:0] left_level;
  logic signed [QUO_W-1:0] q_prop;

  // datapath
  logic                    accept;
  logic                    measure;
  logic [TW-1:0]           period_tw;
  logic [15:0]             period;
  logic [15:0]             err;
  logic                    div_start;
  logic signed [NUM_W-1:0] div_numer;
  logic [DVS_W-1:0]        div_denom;
  logic                    div_done;
  logic signed [QUO_W-1:0] div_quo;
  logic signed [SUM_W-1:0] adj_sum;
  logic signed [CORR_W-1:0] adj;
  logic signed [LVL_W+1:0] lvl_sum;
  logic [LVL_W-1:0]        lvl_new;
  logic                    apply_go;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  // period since the previous edge of the same tread
  assign period_tw = edge_time[TW-1:0] - last_edge[tread];
  assign period    = 16'(period_tw);
  assign err       = period - reference_period;
  assign measure   = accept && !mode && !first_pending[tread];

  // divider gets the error on a left measurement, then the updated integral
  assign div_start = (measure && !tread) || ((state == S_DIVP) && div_done);
  assign div_numer = (state == S_IDLE) ? $signed(err) : $signed(error_integral);
  assign div_denom = (state == S_IDLE) ? prop_div : integ_div;

  tsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (div_denom),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sum of quotients at full width, clamped to a signed byte
  assign adj_sum = SUM_W'(q_prop) + SUM_W'(div_quo);
  always_comb begin
    if (adj_sum > CORR_MAX_WIDE) begin
      adj = CORR_MAX;
    end else if (adj_sum < CORR_MIN_WIDE) begin
      adj = CORR_MIN;
    end else begin
      adj = adj_sum[CORR_W-1:0];
    end
  end

  // level saturates both ways
  assign lvl_sum = $signed({2'b00, left_level}) + (LVL_W+2)'(adj);
  always_comb begin
    if (lvl_sum < 0) begin
      lvl_new = LVL_MIN;
    end else if (lvl_sum > $signed({2'b00, LVL_MAX})) begin
      lvl_new = LVL_MAX;
    end else begin
      lvl_new = lvl_sum[LVL_W-1:0];
    end
  end

  // the integral quotient is flagged by a one-cycle done pulse; the new level
  // is taken on that pulse and the word waits in S_APPLY while the output is full
  assign apply_go = (state == S_DIVI) && div_done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_div  <= PROP_DIV_RST;
      integ_div <= INTEG_DIV_RST;
      init_ref  <= INIT_REF_RST;
      start_lvl <= START_LVL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_DIV:  prop_div  <= cfg_data[DVS_W-1:0];
        REG_INTEG_DIV: integ_div <= cfg_data[DVS_W-1:0];
        REG_INIT_REF:  init_ref  <= cfg_data;
        REG_START_LVL: start_lvl <= cfg_data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      first_pending    <= 2'b11;
      reference_period <= INIT_REF_RST;
      error_integral   <= '0;
      left_level       <= START_LVL_RST;
      out_valid        <= 1'b0;
    end else begin
      if ((state == S_APPLY) && !(out_valid && out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode) begin
              first_pending    <= 2'b11;
              error_integral   <= '0;
              reference_period <= init_ref;
              left_level       <= start_lvl;
            end else if (first_pending[tread]) begin
              first_pending[tread] <= 1'b0;
            end else if (tread) begin
              reference_period <= period;
            end else begin
              error_integral <= error_integral + err;
              state          <= S_DIVP;
            end
          end
        end
        S_DIVP: begin
          if (div_done) begin
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          if (div_done) begin
            left_level <= lvl_new;
            state      <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (!(out_valid && out_stall)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  logic [LVL_W-1:0]         lvl_hold;
  logic signed [CORR_W-1:0] adj_hold;

  always_ff @(posedge clk) begin
    if (accept && !mode) begin
      last_edge[tread] <= edge_time[TW-1:0];
    end
    if ((state == S_DIVP) && div_done) begin
      q_prop <= div_quo;
    end
    if (apply_go) begin
      lvl_hold <= lvl_new;
      adj_hold <= adj;
    end
    if ((state == S_APPLY) && !(out_valid && out_stall)) begin
      drive_level <= lvl_hold;
      correction  <= adj_hold;
    end
  end

  // ----------------------------------------------------------------------------
  // Assertions
  // ----------------------------------------------------------------------------
  a_div_start_phase: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == S_IDLE || state == S_DIVP))
    else $error("divider started outside its phases");

  a_div_done_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVP || state == S_DIVI))
    else $error("divider finished with no pass pending");

  a_apply_issues: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && !(out_valid && out_stall)) |=> (out_valid && state == S_IDLE))
    else $error("apply step did not post a word");

  a_pos_corr_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !correction[CORR_W-1] && correction != '0) |-> (drive_level != LVL_MIN))
    else $error("positive correction left a zero level");

endmodule

`default_nettype wire

@@ sim/tb_tread_speed_pi_sync.sv @@
// ----------------------------------------------------------------------------
// tb_tread_speed_pi_sync: self-checking bench for the tread speed PI block
// Drives encoder edge and restart words through bursty traffic against a
// stalling receiver. A cycle-free mirror of the controller predicts every
// drive word, and results are checked in order under several register sets.
// ----------------------------------------------------------------------------
module tb_tread_speed_pi_sync;
  import tsp_pkg::*;

  // input word codes
  localparam logic MODE_EDGE    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;
  localparam logic TREAD_LEFT   = 1'b0;
  localparam logic TREAD_RIGHT  = 1'b1;

  // quiet margin required after the last result before a held word or config write
  localparam int SETTLE_CYCLES = 48;
  // long receiver hold-off, long enough to back the block up into in_stall
  localparam int LONG_HOLD     = 600;

  typedef struct packed {
    logic        wait_idle;   // sender holds this word until the block drains
    logic        mode;
    logic        tread;
    logic [15:0] edge_time;
  } edge_word_t;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [CORR_W-1:0] corr;
  } drive_word_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  wire                    in_stall;
  logic                   mode      = 1'b0;
  logic                   tread     = 1'b0;
  logic [15:0]            edge_time = '0;
  wire                    out_valid;
  logic                   out_stall = 1'b0;
  wire [LVL_W-1:0]        drive_level;
  wire signed [CORR_W-1:0] correction;
  logic                   cfg_valid = 1'b0;
  wire                    cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  tread_speed_pi_sync #(
    .TIMER_BITS(16)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .tread      (tread),
    .edge_time  (edge_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .drive_level(drive_level),
    .correction (correction),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Mirror of the controller: register copies and speed-loop state
  // --------------------------------------------------------------------------
  logic [DVS_W-1:0] c_prop_div;
  logic [DVS_W-1:0] c_integ_div;
  logic [15:0]      c_init_ref;
  logic [LVL_W-1:0] c_start_level;

  logic [1:0]       m_first_pend;
  logic [15:0]      m_last_edge [2];
  logic [15:0]      m_ref_period;
  logic [15:0]      m_err_integ;
  logic [LVL_W-1:0] m_left_level;

  edge_word_t  pending_q[$];    // words waiting for the sender
  drive_word_t exp_drive_q[$];  // predicted drive words, oldest first

  edge_word_t  cur_word;
  int          errors       = 0;
  int          words_sent   = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          cfg_sets     = 0;
  int          hold_fired   = 0;

  // stimulus generator: per-tread running timer and a flag for the next word
  logic [15:0] gen_time [2];
  bit          hold_next = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    errors++;
  endtask

  task automatic mirror_reset();
    c_prop_div      = PROP_DIV_RST;
    c_integ_div     = INTEG_DIV_RST;
    c_init_ref      = INIT_REF_RST;
    c_start_level   = START_LVL_RST;
    m_first_pend    = 2'b11;
    m_last_edge[0]  = '0;
    m_last_edge[1]  = '0;
    m_ref_period    = INIT_REF_RST;
    m_err_integ     = '0;
    m_left_level    = START_LVL_RST;
  endtask

  // Advance the mirror by one accepted word; a measured left edge queues
  // the drive word it must produce.
  function automatic void predict_drive_update(input edge_word_t w);
    logic [15:0] per;
    logic [15:0] errv;
    int          err;
    int          integ;
    int          pd;
    int          idv;
    int          adj;
    int          lvl;
    drive_word_t d;
    if (w.mode == MODE_RESTART) begin
      m_first_pend = 2'b11;
      m_err_integ  = '0;
      m_ref_period = c_init_ref;
      m_left_level = c_start_level;
    end else if (m_first_pend[w.tread]) begin
      m_last_edge[w.tread]  = w.edge_time;
      m_first_pend[w.tread] = 1'b0;
    end else begin
      per = w.edge_time - m_last_edge[w.tread];
      m_last_edge[w.tread] = w.edge_time;
      if (w.tread == TREAD_RIGHT) begin
        m_ref_period = per;
      end else begin
        errv        = per - m_ref_period;
        m_err_integ = m_err_integ + errv;
        err   = int'($signed(errv));
        integ = int'($signed(m_err_integ));
        // zero divisor behaves as one
        pd  = (c_prop_div  == '0) ? 1 : int'(c_prop_div);
        idv = (c_integ_div == '0) ? 1 : int'(c_integ_div);
        adj = err / pd + integ / idv;
        if (adj > 127)  adj = 127;
        if (adj < -128) adj = -128;
        lvl = int'(m_left_level) + adj;
        if (lvl > 255) lvl = 255;
        if (lvl < 0)   lvl = 0;
        m_left_level = lvl[7:0];
        d.level = lvl[7:0];
        d.corr  = adj[7:0];
        exp_drive_q.push_back(d);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Quiet counter: cycles with nothing accepted, delivered or outstanding
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        exp_drive_q.size() != 0) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < 1000) begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of words with random gaps; a word flagged wait_idle is
  // held back until the block has delivered everything and gone quiet.
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive_p
    logic v_n;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      v_n = in_valid;
      if (in_valid && !in_stall) begin
        predict_drive_update(cur_word);
        words_sent++;
        v_n = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          // back-to-back stretch, no idling
          burst_left = $urandom_range(30, 60);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left   = $urandom_range(1, 15);
        end
      end
      if (!v_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0 &&
                     (!pending_q[0].wait_idle ||
                      (exp_drive_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES))) begin
          cur_word = pending_q.pop_front();
          v_n      = 1'b1;
        end
      end
      // payload only moves when a new word goes out, so a stalled word holds
      in_valid  <= v_n;
      mode      <= cur_word.mode;
      tread     <= cur_word.tread;
      edge_time <= cur_word.edge_time;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: segments of no stall, light and heavy stall,
  // plus two long hold-offs once enough results have gone by.
  // --------------------------------------------------------------------------
  int hold_left;
  int seg_left;
  int seg_kind;

  always @(posedge clk) begin : stall_p
    logic st;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      seg_left  = 0;
      seg_kind  = 0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        st = 1'b1;
      end else if (hold_fired < 2 && results_seen >= ((hold_fired == 0) ? 50 : 200)) begin
        hold_fired++;
        hold_left = LONG_HOLD;
        st = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 2);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (seg_kind)
          0:       st = 1'b0;
          1:       st = ($urandom_range(0, 2) == 0);
          default: st = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_stall <= st;
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_p
    drive_word_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (exp_drive_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word level %0d corr %0d",
                                  drive_level, correction));
      end else begin
        want = exp_drive_q.pop_front();
        if (drive_level !== want.level)
          report_mismatch($sformatf("drive_level got %0d want %0d",
                                    drive_level, want.level));
        if (correction !== want.corr)
          report_mismatch($sformatf("correction got %0d want %0d",
                                    correction, $signed(want.corr)));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_word(input logic m, input logic t, input logic [15:0] tm);
    edge_word_t w;
    w.wait_idle = hold_next;
    w.mode      = m;
    w.tread     = t;
    w.edge_time = tm;
    hold_next   = 1'b0;
    pending_q.push_back(w);
    if (m == MODE_EDGE) gen_time[t] = tm;
  endtask

  function automatic int pick_base();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 300);
      1, 2:    return $urandom_range(300, 5000);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // One run of motion: restart, first edges, then jittered periods with a
  // bit of raw noise mixed in.
  task automatic gen_motion(input int n);
    int   base;
    int   jit;
    int   p;
    int   kind;
    logic t;
    push_word(MODE_RESTART, 1'($urandom), 16'($urandom));
    push_word(MODE_EDGE, TREAD_LEFT, 16'($urandom));
    push_word(MODE_EDGE, TREAD_RIGHT, 16'($urandom));
    base = pick_base();
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        push_word(($urandom_range(0, 7) == 0) ? MODE_RESTART : MODE_EDGE,
                  1'($urandom), 16'($urandom));
      end else if (kind == 1) begin
        base = pick_base();
      end else begin
        t   = (kind < 9) ? TREAD_RIGHT : TREAD_LEFT;
        jit = (kind < 4 || kind > 17) ? base : base / 16 + 1;
        p   = base + int'($urandom_range(0, 2 * jit)) - jit;
        if (p < 0) p = 0;
        push_word(MODE_EDGE, t, gen_time[t] + 16'(p));
      end
    end
  endtask

  task automatic random_phase(input int items, input bit drain);
    int made;
    int n;
    made = 0;
    while (made < items) begin
      n = $urandom_range(8, 40);
      // sender pause: next word waits for every result to come back
      if (drain && made > items / 2) begin
        hold_next = 1'b1;
        drain     = 1'b0;
      end
      gen_motion(n);
      made += n + 3;
    end
  endtask

  // block idle: nothing queued, nothing in flight, margin elapsed
  task automatic wait_quiet();
    while (pending_q.size() != 0 || in_valid || exp_drive_q.size() != 0 ||
           quiet_cycles < SETTLE_CYCLES)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PROP_DIV:  c_prop_div    = val[DVS_W-1:0];
      REG_INTEG_DIV: c_integ_div   = val[DVS_W-1:0];
      REG_INIT_REF:  c_init_ref    = val;
      REG_START_LVL: c_start_level = val[LVL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] pdv, input logic [15:0] idv,
                            input logic [15:0] rf, input logic [15:0] lv);
    wait_quiet();
    write_reg(REG_PROP_DIV, pdv);
    write_reg(REG_INTEG_DIV, idv);
    write_reg(REG_INIT_REF, rf);
    write_reg(REG_START_LVL, lv);
    cfg_sets++;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : seq_p
    int settle;
    mirror_reset();
    gen_time[0] = '0;
    gen_time[1] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset register values: first edges, zero error, timer wrap, period
    // error extremes and restarts with extreme ignored fields
    cfg_sets = 1;
    push_word(MODE_EDGE, TREAD_LEFT,  16'd100);
    push_word(MODE_EDGE, TREAD_RIGHT, 16'd200);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd1100);
    push_word(MODE_EDGE, TREAD_RIGHT, 16'd1200);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd3100);
    push_word(MODE_EDGE, TREAD_LEFT,  16'h0000);
    push_word(MODE_EDGE, TREAD_RIGHT, 16'hFFFF);
    push_word(MODE_EDGE, TREAD_RIGHT, 16'hFFFF);  // zero reference
    push_word(MODE_EDGE, TREAD_LEFT,  16'h8000);  // most negative error
    push_word(MODE_EDGE, TREAD_LEFT,  16'hFFFF);  // most positive error
    push_word(MODE_RESTART, TREAD_RIGHT, 16'hFFFF);
    push_word(MODE_EDGE, TREAD_LEFT,  16'h1234);
    push_word(MODE_EDGE, TREAD_LEFT,  16'h161C);
    push_word(MODE_RESTART, TREAD_LEFT, 16'h0000);

    // unit divisors, zero reference and start level: correction and level
    // saturate both ways
    set_config(16'd1, 16'd1, 16'd0, 16'd0);
    push_word(MODE_RESTART, TREAD_LEFT, 16'h0000);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd0);
    push_word(MODE_EDGE, TREAD_RIGHT, 16'd0);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd10);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd200);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd400);   // level pinned at top
    push_word(MODE_EDGE, TREAD_RIGHT, 16'd5000);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd500);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd600);
    push_word(MODE_EDGE, TREAD_LEFT,  16'd700);   // level pinned at zero

    // zero divisors act as one, reference at top of range
    set_config(16'd0, 16'd0, 16'hFFFF, 16'd255);
    random_phase(110, 1'b0);

    // largest divisors; bit 15 of the divisor data must be dropped
    set_config(16'hFFFF, 16'h7FFF, 16'h8000, 16'd128);
    random_phase(110, 1'b1);

    // integral term dominates
    set_config(16'd200, 16'd8, 16'd1500, 16'd60);
    random_phase(110, 1'b0);

    repeat (2) begin
      set_config(($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 64))
                                             : 16'($urandom_range(1, 32767)),
                 ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 64))
                                             : 16'($urandom_range(1, 32767)),
                 16'($urandom), 16'($urandom_range(0, 255)));
      random_phase(110, 1'b1);
    end

    // drain: all words out, results back, then a margin
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    settle = 0;
    while (exp_drive_q.size() != 0 && settle < 20000) begin
      @(posedge clk);
      settle++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (exp_drive_q.size() != 0)
      report_mismatch($sformatf("%0d predicted drive words never arrived",
                                exp_drive_q.size()));

    $display("Sent %0d edge/restart words, checked %0d drive words over %0d register sets.",
             words_sent, results_seen, cfg_sets);
    $display("Long receiver hold-offs: %0d, mismatches: %0d.", hold_fired, errors);
    if (errors == 0) begin
      $display("tread_speed_pi_sync test passed");
    end else begin
      $display("tread_speed_pi_sync test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tread_speed_pi_sync test failed");
    $finish;
  end

endmodule

@@ sim.f @@
src/tsp_pkg.sv
src/tsp_div.sv
src/tread_speed_pi_sync.sv
sim/tb_tread_speed_pi_sync.sv
